// ===== hdl/hcb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// types and constants shared by the huffman code builder files
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int FUNC_W       = 2;
   localparam int BYTE_W       = 8;
   localparam int CODE_FIELD_W = 48;
   localparam int LEN_FIELD_W  = 6;
   localparam int DISTINCT_W   = 9;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_COUNT  = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_LK_RD,
      ST_LK_OUT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_INS_START,
      ST_INS_HEAD,
      ST_INS_LINK,
      ST_INS_CMP,
      ST_INS_FIX,
      ST_MRG_A,
      ST_MRG_B,
      ST_MRG_C,
      ST_ASG_ROOT,
      ST_ASG_RD,
      ST_ASG_C0,
      ST_ASG_C1,
      ST_OUT_RD,
      ST_OUT_WR,
      ST_BLD_DONE
   } state_type;

   typedef struct packed {
      logic lt;
      logic le;
   } alu_flags_type;

endpackage
`default_nettype wire

// ===== hdl/hcb_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_req_if
// request channel: function code and byte
// ----------------------------------------------------------------------------
interface hcb_req_if import hcb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/hcb_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_rsp_if
// response channel: code word, length and build information
// ----------------------------------------------------------------------------
interface hcb_rsp_if import hcb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CODE_FIELD_W-1:0] code_bits;
   logic [LEN_FIELD_W-1:0]  code_length;
   logic                    symbol_known;
   logic [DISTINCT_W-1:0]   distinct_symbols;
   logic                    build_status;

   modport source (output valid, output code_bits, output code_length,
                   output symbol_known, output distinct_symbols,
                   output build_status, input ready);
   modport sink   (input valid, input code_bits, input code_length,
                   input symbol_known, input distinct_symbols,
                   input build_status, output ready);
endinterface
`default_nettype wire

// ===== hdl/huffman_code_builder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_builder
// byte histogram with saturating counts, huffman code build over a sorted
// linked queue of nodes, and per-byte code lookup
// ----------------------------------------------------------------------------
// count: histogram entry read, then written back
// lookup: tables read, then response registered when free; ready again after that
// build: a scan of the histogram over ALPHABET_SIZE entries, a sorted insert
//   for each nonzero count and each merge, walking the queue nodes, then code
//   assignment and a write per symbol; the single weight adder/compare sets the pace
// reset: histogram and code tables read as zero at once through valid bits
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; #(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_BITS    = 24,
   parameter int MAX_CODE_LEN  = 48
) (
   input  logic       clock,
   input  logic       reset,
   hcb_req_if.sink    req_ch,
   hcb_rsp_if.source  rsp_ch
);

   localparam int IDX_W    = $clog2(ALPHABET_SIZE);
   localparam int CTR_W    = IDX_W + 1;
   localparam int NODE_CNT = 2 * ALPHABET_SIZE - 1;
   localparam int NODE_W   = $clog2(2 * ALPHABET_SIZE);
   localparam int WGT_W    = COUNT_BITS + IDX_W;
   localparam int LEN_W    = $clog2(MAX_CODE_LEN + 1);
   localparam int CODE_W   = MAX_CODE_LEN;
   localparam logic [NODE_W-1:0] NO_NODE = '1;

   // state and control registers
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [ALPHABET_SIZE-1:0] cnt_vld_ff, cnt_vld_in;
   logic [ALPHABET_SIZE-1:0] code_vld_ff, code_vld_in;
   logic [DISTINCT_W-1:0] last_distinct_ff, last_distinct_in;
   logic rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic range_ff, range_in;
   logic [CTR_W-1:0] s_ff, s_in, leaves_ff, leaves_in, live_ff, live_in;
   logic [CTR_W-1:0] i_ff, i_in;
   logic [NODE_W-1:0] head_ff, head_in, cur_ff, cur_in, nxt_ff, nxt_in;
   logic [NODE_W-1:0] ins_idx_ff, ins_idx_in, a_ff, a_in, b_ff, b_in;
   logic [NODE_W-1:0] total_ff, total_in, p_ff, p_in, ch1_ff, ch1_in;
   logic [WGT_W-1:0] ins_w_ff, ins_w_in, aw_ff, aw_in;
   logic [CODE_W-1:0] c1_code_ff, c1_code_in;
   logic [LEN_W-1:0] c1_len_ff, c1_len_in;
   logic [CODE_FIELD_W-1:0] rsp_code_ff, rsp_code_in;
   logic [LEN_FIELD_W-1:0] rsp_len_ff, rsp_len_in;
   logic rsp_known_ff, rsp_known_in, rsp_status_ff, rsp_status_in;
   logic [DISTINCT_W-1:0] rsp_dist_ff, rsp_dist_in;

   // memories
   logic [COUNT_BITS-1:0] count_mem [ALPHABET_SIZE];
   logic [WGT_W-1:0] weight_mem [NODE_CNT];
   logic [2*NODE_W-1:0] child_mem [NODE_CNT];
   logic [NODE_W-1:0] link_mem [NODE_CNT];
   logic [IDX_W-1:0] sym_mem [ALPHABET_SIZE];
   logic [CODE_W+LEN_W-1:0] ncode_mem [NODE_CNT];
   logic [CODE_W-1:0] cword_mem [ALPHABET_SIZE];
   logic [LEN_W-1:0] clen_mem [ALPHABET_SIZE];

   // memory read data
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic cnt_vld_rd_ff, code_vld_rd_ff;
   logic [WGT_W-1:0] weight_rd_ff;
   logic [2*NODE_W-1:0] child_rd_ff;
   logic [NODE_W-1:0] link_rd_ff;
   logic [IDX_W-1:0] sym_rd_ff;
   logic [CODE_W+LEN_W-1:0] ncode_rd_ff;
   logic [CODE_W-1:0] cword_rd_ff;
   logic [LEN_W-1:0] clen_rd_ff;

   // memory controls
   logic [IDX_W-1:0] count_raddr, code_raddr, sym_addr;
   logic count_we, cword_we, weight_we, child_we, link_we, sym_we, ncode_we;
   logic [IDX_W-1:0] count_waddr, cword_waddr;
   logic [COUNT_BITS-1:0] count_wdata;
   logic [NODE_W-1:0] weight_raddr, link_raddr, child_raddr, ncode_raddr;
   logic [NODE_W-1:0] weight_waddr, link_waddr, child_waddr, ncode_waddr;
   logic [WGT_W-1:0] weight_wdata;
   logic [NODE_W-1:0] link_wdata;
   logic [CODE_W+LEN_W-1:0] ncode_wdata;

   // shared unit
   logic [WGT_W-1:0] alu_a, alu_b, alu_sum;
   alu_flags_type alu_flags;

   logic req_fire, rsp_free;
   func_type req_func;
   logic [WGT_W-1:0] cnt_ext;
   logic [CODE_W-1:0] par_code, c0_code, c1_code;
   logic [LEN_W-1:0] par_len, c_len;

   hcb_alu #(.WIDTH(WGT_W)) u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_func     = func_type'(req_ch.func);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign cnt_ext  = cnt_vld_rd_ff ? WGT_W'(count_rd_ff) : '0;
   assign par_code = ncode_rd_ff[CODE_W+LEN_W-1:LEN_W];
   assign par_len  = ncode_rd_ff[LEN_W-1:0];

   always_comb begin
      if (par_len < LEN_W'(MAX_CODE_LEN)) begin
         c0_code = {par_code[CODE_W-2:0], 1'b0};
         c1_code = {par_code[CODE_W-2:0], 1'b1};
         c_len   = par_len + LEN_W'(1);
      end else begin
         c0_code = par_code;
         c1_code = par_code;
         c_len   = par_len;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.code_bits        = rsp_code_ff;
   assign rsp_ch.code_length      = rsp_len_ff;
   assign rsp_ch.symbol_known     = rsp_known_ff;
   assign rsp_ch.distinct_symbols = rsp_dist_ff;
   assign rsp_ch.build_status     = rsp_status_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_func)
                  FUNC_COUNT:  state_in = ST_CNT_RD;
                  FUNC_BUILD:  state_in = ST_SCAN_RD;
                  FUNC_LOOKUP: state_in = ST_LK_RD;
                  FUNC_CLEAR:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_CNT_RD:    state_in = ST_CNT_WR;
         ST_CNT_WR:    state_in = ST_IDLE;
         ST_LK_RD:     state_in = ST_LK_OUT;
         ST_LK_OUT:    state_in = rsp_free ? ST_IDLE : ST_LK_OUT;
         ST_SCAN_RD: begin
            if (s_ff == CTR_W'(ALPHABET_SIZE)) begin
               state_in = (leaves_ff == '0) ? ST_BLD_DONE : ST_MRG_A;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK:  state_in = (cnt_ext != '0) ? ST_INS_START : ST_SCAN_RD;
         ST_INS_START: state_in = (head_ff == NO_NODE) ? ret_ff : ST_INS_HEAD;
         ST_INS_HEAD:  state_in = alu_flags.lt ? ret_ff : ST_INS_LINK;
         ST_INS_LINK:  state_in = (link_rd_ff == NO_NODE) ? ST_INS_FIX : ST_INS_CMP;
         ST_INS_CMP:   state_in = alu_flags.le ? ST_INS_LINK : ST_INS_FIX;
         ST_INS_FIX:   state_in = ret_ff;
         ST_MRG_A:     state_in = (live_ff > CTR_W'(1)) ? ST_MRG_B : ST_ASG_ROOT;
         ST_MRG_B:     state_in = ST_MRG_C;
         ST_MRG_C:     state_in = ST_INS_START;
         ST_ASG_ROOT:  state_in = ST_ASG_RD;
         ST_ASG_RD:    state_in = (p_ff < NODE_W'(leaves_ff)) ? ST_OUT_RD : ST_ASG_C0;
         ST_ASG_C0:    state_in = ST_ASG_C1;
         ST_ASG_C1:    state_in = ST_ASG_RD;
         ST_OUT_RD:    state_in = (i_ff == leaves_ff) ? ST_BLD_DONE : ST_OUT_WR;
         ST_OUT_WR:    state_in = ST_OUT_RD;
         ST_BLD_DONE:  state_in = rsp_free ? ST_IDLE : ST_BLD_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      ret_in           = ret_ff;
      cnt_vld_in       = cnt_vld_ff;
      code_vld_in      = code_vld_ff;
      last_distinct_in = last_distinct_ff;
      idx_in           = idx_ff;
      range_in         = range_ff;
      s_in             = s_ff;
      leaves_in        = leaves_ff;
      live_in          = live_ff;
      i_in             = i_ff;
      head_in          = head_ff;
      cur_in           = cur_ff;
      nxt_in           = nxt_ff;
      ins_idx_in       = ins_idx_ff;
      a_in             = a_ff;
      b_in             = b_ff;
      total_in         = total_ff;
      p_in             = p_ff;
      ch1_in           = ch1_ff;
      ins_w_in         = ins_w_ff;
      aw_in            = aw_ff;
      c1_code_in       = c1_code_ff;
      c1_len_in        = c1_len_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_known_in     = rsp_known_ff;
      rsp_dist_in      = rsp_dist_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;

      count_raddr  = idx_ff;
      code_raddr   = idx_ff;
      sym_addr     = i_ff[IDX_W-1:0];
      count_we     = 1'b0;
      count_waddr  = idx_ff;
      count_wdata  = alu_sum[COUNT_BITS-1:0];
      cword_we     = 1'b0;
      cword_waddr  = sym_rd_ff;
      sym_we       = 1'b0;
      weight_raddr = head_ff;
      weight_we    = 1'b0;
      weight_waddr = total_ff;
      weight_wdata = alu_sum;
      link_raddr   = head_ff;
      link_we      = 1'b0;
      link_waddr   = ins_idx_ff;
      link_wdata   = nxt_ff;
      child_raddr  = p_ff;
      child_we     = 1'b0;
      child_waddr  = total_ff;
      ncode_raddr  = p_ff;
      ncode_we     = 1'b0;
      ncode_waddr  = p_ff;
      ncode_wdata  = '0;
      alu_a        = cnt_ext;
      alu_b        = WGT_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in   = req_ch.data_byte[IDX_W-1:0];
               range_in = ({1'b0, req_ch.data_byte} < (BYTE_W+1)'(ALPHABET_SIZE));
               unique case (req_func)
                  FUNC_BUILD: begin
                     code_vld_in = '0;
                     s_in        = '0;
                     leaves_in   = '0;
                     head_in     = NO_NODE;
                  end
                  FUNC_CLEAR: begin
                     cnt_vld_in       = '0;
                     code_vld_in      = '0;
                     last_distinct_in = '0;
                  end
                  FUNC_COUNT, FUNC_LOOKUP: begin
                  end
               endcase
            end
         end
         ST_CNT_WR: begin
            if (range_ff && !alu_sum[COUNT_BITS]) begin
               count_we           = 1'b1;
               cnt_vld_in[idx_ff] = 1'b1;
            end
         end
         ST_LK_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_known_in  = range_ff && code_vld_rd_ff;
               rsp_code_in   = (range_ff && code_vld_rd_ff) ?
                               CODE_FIELD_W'(cword_rd_ff) : '0;
               rsp_len_in    = (range_ff && code_vld_rd_ff) ?
                               LEN_FIELD_W'(clen_rd_ff) : '0;
               rsp_dist_in   = last_distinct_ff;
               rsp_status_in = 1'b0;
            end
         end
         ST_SCAN_RD: begin
            count_raddr = s_ff[IDX_W-1:0];
            if (s_ff == CTR_W'(ALPHABET_SIZE)) begin
               last_distinct_in = DISTINCT_W'(leaves_ff);
               total_in         = NODE_W'(leaves_ff);
               live_in          = leaves_ff;
            end
         end
         ST_SCAN_CHK: begin
            s_in = s_ff + CTR_W'(1);
            if (cnt_ext != '0) begin
               weight_we    = 1'b1;
               weight_waddr = NODE_W'(leaves_ff);
               weight_wdata = cnt_ext;
               sym_we       = 1'b1;
               sym_addr     = leaves_ff[IDX_W-1:0];
               ins_idx_in   = NODE_W'(leaves_ff);
               ins_w_in     = cnt_ext;
               leaves_in    = leaves_ff + CTR_W'(1);
               ret_in       = ST_SCAN_RD;
            end
         end
         ST_INS_START: begin
            weight_raddr = head_ff;
            if (head_ff == NO_NODE) begin
               link_we    = 1'b1;
               link_wdata = NO_NODE;
               head_in    = ins_idx_ff;
            end
         end
         ST_INS_HEAD: begin
            alu_a      = ins_w_ff;
            alu_b      = weight_rd_ff;
            link_raddr = head_ff;
            cur_in     = head_ff;
            if (alu_flags.lt) begin
               link_we    = 1'b1;
               link_wdata = head_ff;
               head_in    = ins_idx_ff;
            end
         end
         ST_INS_LINK: begin
            nxt_in       = link_rd_ff;
            weight_raddr = link_rd_ff;
            if (link_rd_ff == NO_NODE) begin
               link_we    = 1'b1;
               link_wdata = NO_NODE;
            end
         end
         ST_INS_CMP: begin
            alu_a      = weight_rd_ff;
            alu_b      = ins_w_ff;
            link_raddr = nxt_ff;
            if (alu_flags.le) begin
               cur_in = nxt_ff;
            end else begin
               link_we    = 1'b1;
               link_wdata = nxt_ff;
            end
         end
         ST_INS_FIX: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = ins_idx_ff;
         end
         ST_MRG_A: begin
            a_in         = head_ff;
            link_raddr   = head_ff;
            weight_raddr = head_ff;
         end
         ST_MRG_B: begin
            aw_in        = weight_rd_ff;
            b_in         = link_rd_ff;
            link_raddr   = link_rd_ff;
            weight_raddr = link_rd_ff;
         end
         ST_MRG_C: begin
            alu_a      = aw_ff;
            alu_b      = weight_rd_ff;
            head_in    = link_rd_ff;
            weight_we  = 1'b1;
            child_we   = 1'b1;
            ins_idx_in = total_ff;
            ins_w_in   = alu_sum;
            ret_in     = ST_MRG_A;
            total_in   = total_ff + NODE_W'(1);
            live_in    = live_ff - CTR_W'(1);
         end
         ST_ASG_ROOT: begin
            p_in        = total_ff - NODE_W'(1);
            ncode_we    = 1'b1;
            ncode_waddr = total_ff - NODE_W'(1);
            ncode_wdata = '0;
         end
         ST_ASG_RD: begin
            child_raddr = p_ff;
            ncode_raddr = p_ff;
            i_in        = '0;
         end
         ST_ASG_C0: begin
            ncode_we    = 1'b1;
            ncode_waddr = child_rd_ff[2*NODE_W-1:NODE_W];
            ncode_wdata = {c0_code, c_len};
            ch1_in      = child_rd_ff[NODE_W-1:0];
            c1_code_in  = c1_code;
            c1_len_in   = c_len;
         end
         ST_ASG_C1: begin
            ncode_we    = 1'b1;
            ncode_waddr = ch1_ff;
            ncode_wdata = {c1_code_ff, c1_len_ff};
            p_in        = p_ff - NODE_W'(1);
         end
         ST_OUT_RD: begin
            sym_addr    = i_ff[IDX_W-1:0];
            ncode_raddr = NODE_W'(i_ff);
         end
         ST_OUT_WR: begin
            cword_we                = 1'b1;
            code_vld_in[sym_rd_ff]  = 1'b1;
            i_in                    = i_ff + CTR_W'(1);
         end
         ST_BLD_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_known_in  = 1'b0;
               rsp_code_in   = '0;
               rsp_len_in    = '0;
               rsp_dist_in   = DISTINCT_W'(leaves_ff);
               rsp_status_in = (leaves_ff == '0);
            end
         end
         ST_CNT_RD, ST_LK_RD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ret_ff           <= ST_IDLE;
         cnt_vld_ff       <= '0;
         code_vld_ff      <= '0;
         last_distinct_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         ret_ff           <= ret_in;
         cnt_vld_ff       <= cnt_vld_in;
         code_vld_ff      <= code_vld_in;
         last_distinct_ff <= last_distinct_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      range_ff      <= range_in;
      s_ff          <= s_in;
      leaves_ff     <= leaves_in;
      live_ff       <= live_in;
      i_ff          <= i_in;
      head_ff       <= head_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      ins_idx_ff    <= ins_idx_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      total_ff      <= total_in;
      p_ff          <= p_in;
      ch1_ff        <= ch1_in;
      ins_w_ff      <= ins_w_in;
      aw_ff         <= aw_in;
      c1_code_ff    <= c1_code_in;
      c1_len_ff     <= c1_len_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_known_ff  <= rsp_known_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_waddr] <= count_wdata;
      end
      count_rd_ff   <= count_mem[count_raddr];
      cnt_vld_rd_ff <= cnt_vld_ff[count_raddr];
   end

   always_ff @(posedge clock) begin
      if (cword_we) begin
         cword_mem[cword_waddr] <= ncode_rd_ff[CODE_W+LEN_W-1:LEN_W];
         clen_mem[cword_waddr]  <= ncode_rd_ff[LEN_W-1:0];
      end
      cword_rd_ff    <= cword_mem[code_raddr];
      clen_rd_ff     <= clen_mem[code_raddr];
      code_vld_rd_ff <= code_vld_ff[code_raddr];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_addr] <= s_ff[IDX_W-1:0];
      end
      sym_rd_ff <= sym_mem[sym_addr];
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[weight_waddr] <= weight_wdata;
      end
      weight_rd_ff <= weight_mem[weight_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_waddr] <= {a_ff, b_ff};
      end
      child_rd_ff <= child_mem[child_raddr];
   end

   always_ff @(posedge clock) begin
      if (ncode_we) begin
         ncode_mem[ncode_waddr] <= ncode_wdata;
      end
      ncode_rd_ff <= ncode_mem[ncode_raddr];
   end

   // checks
   a_merge_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MRG_A && live_ff > CTR_W'(1)) |-> (head_ff != NO_NODE))
      else $error("merge with empty queue");

   a_leaves_bound: assert property (@(posedge clock) disable iff (reset)
      (leaves_ff <= CTR_W'(ALPHABET_SIZE)) || (state_ff == ST_IDLE))
      else $error("leaf count out of range");

   a_clear_distinct: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == FUNC_CLEAR) |=> (last_distinct_ff == '0))
      else $error("clear left distinct count");

   a_count_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_func == FUNC_COUNT && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("response raised by count");

endmodule
`default_nettype wire

// ===== hdl/hcb_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_alu
// shared adder and magnitude compare for weights and counts
// ----------------------------------------------------------------------------
module hcb_alu import hcb_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] sum,
   output alu_flags_type    flags
);

   assign sum      = op_a + op_b;
   assign flags.lt = (op_a < op_b);
   assign flags.le = (op_a <= op_b);

endmodule
`default_nettype wire
